FILE: hw/rtl/ecf_sched_pkg.sv
// Shared types and constants of the ECF multipath scheduler.
// No dependencies; the interfaces, controller, datapath and top level import this package.
package ecf_sched_pkg;

  localparam int SRTT_W  = 24;
  localparam int BYTE_W  = 32;
  localparam int PKT_W   = 16;
  localparam int SLOT_W  = 3;
  localparam int BETA_W  = 4;
  localparam int K_W     = BYTE_W + 1;          // packet_size + queued
  localparam int MA_W    = K_W + 1;             // widest multiplier operand a
  localparam int MP_W    = MA_W + BYTE_W;       // raw multiplier product
  localparam int PROD_W  = 58;                  // widest product that occurs
  localparam int SCL_W   = PROD_W + BETA_W;     // product times beta(+1)

  localparam logic [BETA_W-1:0] BETA_RESET = BETA_W'(4);

  localparam logic ACT_WRITE   = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  typedef struct packed {
    logic [SRTT_W-1:0] srtt;
    logic [SRTT_W-1:0] rttvar;
    logic [BYTE_W-1:0] cwnd;
    logic [BYTE_W-1:0] inflight;
    logic [BYTE_W-1:0] queued;
    logic              amp_blocked;
  } rec_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_SCAN_END, ST_CHECK, ST_PREP, ST_MUL_A, ST_MUL_B,
    ST_SCALE, ST_MUL_C, ST_MUL_D, ST_DECIDE, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    MUL_NONE, MUL_A, MUL_B, MUL_C, MUL_D
  } mul_op_t;

  typedef struct packed {
    logic    wr_rec;
    logic    start;
    logic    scan_rd;
    logic    prep;
    mul_op_t mul_op;
    logic    scale;
    logic    decide;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic need_ecf;
    logic out_busy;
  } sts_t;

endpackage

FILE: hw/rtl/ecf_sched_ifs.sv
// Channel interfaces of the ECF multipath scheduler: request, result, config.
// Depends on ecf_sched_pkg for field widths.
interface ecf_sched_in_if import ecf_sched_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [SLOT_W-1:0] slot;
  logic              active;
  logic [SRTT_W-1:0] srtt;
  logic [SRTT_W-1:0] rttvar;
  logic [BYTE_W-1:0] cwnd;
  logic [BYTE_W-1:0] inflight;
  logic [BYTE_W-1:0] backlog;
  logic              amp_blocked;
  logic [PKT_W-1:0]  packet_size;
  logic              check;
  logic              reinject;

  modport source (output valid, action, slot, active, srtt, rttvar, cwnd, inflight,
                  backlog, amp_blocked, packet_size, check, reinject,
                  input ready);
  modport sink (input valid, action, slot, active, srtt, rttvar, cwnd, inflight,
                backlog, amp_blocked, packet_size, check, reinject,
                output ready);
endinterface

interface ecf_sched_out_if import ecf_sched_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              chosen_valid;
  logic [SLOT_W-1:0] chosen_path;
  logic              waiting;

  modport source (output valid, chosen_valid, chosen_path, waiting, input ready);
  modport sink (input valid, chosen_valid, chosen_path, waiting, output ready);
endinterface

interface ecf_sched_cfg_if import ecf_sched_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BETA_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: hw/rtl/ecf_sched_ram.sv
// Generic simple dual-port RAM with registered read data.
// No dependencies.
module ecf_sched_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  logic [WIDTH-1:0]                   wdata,
  input  logic                               re,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic [WIDTH-1:0]                   rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: hw/rtl/ecf_sched_ctrl.sv
// Controller state machine of the ECF multipath scheduler.
// Depends on ecf_sched_pkg; drives cmd_t to the datapath, reads sts_t back.
module ecf_sched_ctrl import ecf_sched_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_action,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_action == ACT_REQUEST) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_last) state_nxt = ST_SCAN_END;
      end
      ST_SCAN_END: state_nxt = ST_CHECK;
      ST_CHECK:    state_nxt = sts.need_ecf ? ST_PREP : ST_DECIDE;
      ST_PREP:     state_nxt = ST_MUL_A;
      ST_MUL_A:    state_nxt = ST_MUL_B;
      ST_MUL_B:    state_nxt = ST_SCALE;
      ST_SCALE:    state_nxt = ST_MUL_C;
      ST_MUL_C:    state_nxt = ST_MUL_D;
      ST_MUL_D:    state_nxt = ST_DECIDE;
      ST_DECIDE:   state_nxt = ST_OUT;
      ST_OUT: begin
        if (!sts.out_busy) state_nxt = ST_IDLE;
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.mul_op = MUL_NONE;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.wr_rec = in_valid && in_action == ACT_WRITE;
        cmd.start  = in_valid && in_action == ACT_REQUEST;
      end
      ST_SCAN:   cmd.scan_rd  = 1'b1;
      ST_PREP:   cmd.prep     = 1'b1;
      ST_MUL_A:  cmd.mul_op   = MUL_A;
      ST_MUL_B:  cmd.mul_op   = MUL_B;
      ST_SCALE:  cmd.scale    = 1'b1;
      ST_MUL_C:  cmd.mul_op   = MUL_C;
      ST_MUL_D:  cmd.mul_op   = MUL_D;
      ST_DECIDE: cmd.decide   = 1'b1;
      ST_OUT:    cmd.load_out = !sts.out_busy;
      default: ;
    endcase
  end
endmodule

FILE: hw/rtl/ecf_sched_dp.sv
// Datapath of the ECF multipath scheduler: path table, scan, shared multiplier,
// decision and result register. Depends on ecf_sched_pkg and ecf_sched_ram.
module ecf_sched_dp import ecf_sched_pkg::*; #(
  parameter int NUM_PATHS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [SLOT_W-1:0] in_slot,
  input  logic              in_active,
  input  logic [SRTT_W-1:0] in_srtt,
  input  logic [SRTT_W-1:0] in_rttvar,
  input  logic [BYTE_W-1:0] in_cwnd,
  input  logic [BYTE_W-1:0] in_inflight,
  input  logic [BYTE_W-1:0] in_backlog,
  input  logic              in_amp_blocked,
  input  logic [PKT_W-1:0]  in_packet_size,
  input  logic              in_check,
  input  logic              in_reinject,
  input  logic              cfg_valid,
  input  logic [BETA_W-1:0] cfg_data,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              out_chosen_valid,
  output logic [SLOT_W-1:0] out_chosen_path,
  output logic              out_waiting
);
  localparam int IW = (NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1;
  localparam int CW = (IW > SLOT_W) ? IW : SLOT_W;
  localparam logic [IW-1:0] LAST = IW'(NUM_PATHS - 1);

  logic [BETA_W-1:0] beta_r;
  logic              waiting_r;
  logic [NUM_PATHS-1:0] act_r;

  logic [CW-1:0] slot_ext;
  logic          slot_ok;
  rec_t          wr_rec, rd_rec;

  logic [CW-1:0]    req_slot_r;
  logic [PKT_W-1:0] req_pkt_r;
  logic             req_check_r, req_reinject_r;

  logic [IW-1:0] idx_r, eval_idx_r, fast_idx_r, best_idx_r;
  logic          eval_vld_r, have_fast_r, have_best_r;
  rec_t          fast_r, best_r;
  logic          consider, sendable, take_fast, take_best;

  logic [K_W-1:0]    k_r, k_sum;
  logic [SRTT_W-1:0] delta_r;
  logic [MA_W-1:0]   mul_a;
  logic [BYTE_W-1:0] mul_b;
  logic [MP_W-1:0]   mul_p;
  logic [PROD_W-1:0] prod_a_r, prod_b_r;
  logic [SCL_W-1:0]  lhs_r, rhs_r;
  logic              need, lt, gt, res_chosen_r;
  logic [CW-1:0]     best_ext;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_r <= BETA_RESET;
    end else if (cfg_valid) begin
      beta_r <= cfg_data;
    end
  end

  // path table: active bits in flops, the rest in RAM
  assign slot_ext = CW'(in_slot);
  assign slot_ok  = {1'b0, slot_ext} < (CW+1)'(NUM_PATHS);
  assign wr_rec   = '{srtt: in_srtt, rttvar: in_rttvar, cwnd: in_cwnd,
                      inflight: in_inflight, queued: in_backlog,
                      amp_blocked: in_amp_blocked};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= '0;
    end else if (cmd.wr_rec && slot_ok) begin
      act_r[slot_ext[IW-1:0]] <= in_active;
    end
  end

  ecf_sched_ram #(.WIDTH($bits(rec_t)), .DEPTH(NUM_PATHS)) u_tbl (
    .clk   (clk),
    .we    (cmd.wr_rec && slot_ok),
    .waddr (slot_ext[IW-1:0]),
    .wdata (wr_rec),
    .re    (cmd.scan_rd),
    .raddr (idx_r),
    .rdata (rd_rec)
  );

  // request capture and scan
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_slot_r     <= slot_ext;
      req_pkt_r      <= in_packet_size;
      req_check_r    <= in_check;
      req_reinject_r <= in_reinject;
    end
  end

  assign consider = eval_vld_r && act_r[eval_idx_r] &&
                    !(req_reinject_r && CW'(eval_idx_r) == req_slot_r);
  assign sendable = !rd_rec.amp_blocked && (rd_rec.inflight < rd_rec.cwnd) &&
                    (rd_rec.queued <= rd_rec.cwnd - rd_rec.inflight);
  assign take_fast = consider && (!have_fast_r || rd_rec.srtt < fast_r.srtt);
  assign take_best = consider && (!req_check_r || sendable) &&
                     (!have_best_r || rd_rec.srtt < best_r.srtt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eval_vld_r  <= 1'b0;
      have_fast_r <= 1'b0;
      have_best_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      eval_vld_r <= cmd.scan_rd;
      if (cmd.start) begin
        idx_r       <= '0;
        have_fast_r <= 1'b0;
        have_best_r <= 1'b0;
      end else begin
        if (cmd.scan_rd) idx_r <= idx_r + 1'b1;
        if (take_fast) have_fast_r <= 1'b1;
        if (take_best) have_best_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    eval_idx_r <= idx_r;
    if (take_fast) begin
      fast_r     <= rd_rec;
      fast_idx_r <= eval_idx_r;
    end
    if (take_best) begin
      best_r     <= rd_rec;
      best_idx_r <= eval_idx_r;
    end
  end

  assign sts.scan_last = idx_r == LAST;
  assign need = have_best_r && have_fast_r && best_idx_r != fast_idx_r;
  assign sts.need_ecf = need;

  // completion-time test on one shared multiplier
  assign k_sum = K_W'(req_pkt_r) + K_W'(fast_r.queued);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_op)
      MUL_A: begin
        mul_a = MA_W'(k_r) + MA_W'(fast_r.cwnd);
        mul_b = BYTE_W'(fast_r.srtt);
      end
      MUL_B: begin
        mul_a = MA_W'(best_r.srtt) + MA_W'(delta_r);
        mul_b = fast_r.cwnd;
      end
      MUL_C: begin
        mul_a = MA_W'(k_r);
        mul_b = BYTE_W'(best_r.srtt);
      end
      MUL_D: begin
        mul_a = MA_W'({fast_r.srtt, 1'b0}) + MA_W'(delta_r);
        mul_b = best_r.cwnd;
      end
      default: ;
    endcase
  end
  assign mul_p = MP_W'(mul_a) * MP_W'(mul_b);

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      k_r     <= (k_sum > K_W'(fast_r.cwnd)) ? k_sum : K_W'(fast_r.cwnd);
      delta_r <= (fast_r.rttvar > best_r.rttvar) ? fast_r.rttvar : best_r.rttvar;
    end
    if (cmd.mul_op == MUL_A || cmd.mul_op == MUL_C) prod_a_r <= mul_p[PROD_W-1:0];
    if (cmd.mul_op == MUL_B || cmd.mul_op == MUL_D) prod_b_r <= mul_p[PROD_W-1:0];
    if (cmd.scale) begin
      lhs_r <= SCL_W'(prod_a_r) * SCL_W'(beta_r);
      rhs_r <= SCL_W'(prod_b_r) * SCL_W'(SCL_W'(beta_r) + SCL_W'(waiting_r));
    end
  end

  assign lt = lhs_r < rhs_r;
  assign gt = prod_a_r > prod_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r <= 1'b0;
    end else if (cmd.decide && need) begin
      if (!lt) begin
        waiting_r <= 1'b0;
      end else if (gt) begin
        waiting_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      res_chosen_r <= need ? !(lt && gt) : have_best_r;
    end
  end

  // result register
  assign best_ext = CW'(best_idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_chosen_valid <= res_chosen_r;
      out_chosen_path  <= res_chosen_r ? best_ext[SLOT_W-1:0] : '0;
      out_waiting      <= waiting_r;
    end
  end

  assign sts.out_busy = out_valid && !out_ready;
endmodule

FILE: hw/rtl/ecf_multipath_scheduler_unit.sv
// Top level of the ECF multipath scheduler: request, result and config channels.
// Depends on ecf_sched_pkg, ecf_sched_ifs, ecf_sched_ctrl and ecf_sched_dp.
//
// A record write (action 0) updates one path entry and gives no result. A
// path request (action 1) scans the table one entry per cycle through the
// path RAM, keeping the lowest-RTT active path and the lowest-RTT path that
// can send (any active path when check is clear), then, when they differ,
// runs the completion-time test on one shared 34x32 multiplier. The scan
// uses the single RAM read port; the test steps through prep, products A
// and B, scale and products C and D before the decision and the output load.
// One request is in work at a time; writes are taken only between requests.
// The result sits in an output register, and the block takes the next
// request while it waits. The beta register is written at any time with
// no wait and resets to 4; write it only while the block is idle.
module ecf_multipath_scheduler_unit import ecf_sched_pkg::*; #(
  parameter int NUM_PATHS = 8
) (
  input logic         clk,
  input logic         rst_n,
  ecf_sched_in_if.sink   in_req,
  ecf_sched_out_if.source out_res,
  ecf_sched_cfg_if.sink  cfg_wr
);
  cmd_t cmd;
  sts_t sts;

  // config writes never stall
  assign cfg_wr.ready = 1'b1;

  ecf_sched_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_action (in_req.action),
    .in_ready  (in_req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ecf_sched_dp #(.NUM_PATHS(NUM_PATHS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_slot          (in_req.slot),
    .in_active        (in_req.active),
    .in_srtt          (in_req.srtt),
    .in_rttvar        (in_req.rttvar),
    .in_cwnd          (in_req.cwnd),
    .in_inflight      (in_req.inflight),
    .in_backlog       (in_req.backlog),
    .in_amp_blocked   (in_req.amp_blocked),
    .in_packet_size   (in_req.packet_size),
    .in_check         (in_req.check),
    .in_reinject      (in_req.reinject),
    .cfg_valid        (cfg_wr.valid),
    .cfg_data         (cfg_wr.data),
    .out_ready        (out_res.ready),
    .out_valid        (out_res.valid),
    .out_chosen_valid (out_res.chosen_valid),
    .out_chosen_path  (out_res.chosen_path),
    .out_waiting      (out_res.waiting)
  );
endmodule
